/* sv/adc_channel_averager_temp_filter_defines.svh */
// assertion macros used by the checker file
`ifndef ADC_CHANNEL_AVERAGER_TEMP_FILTER_DEFINES_SVH
`define ADC_CHANNEL_AVERAGER_TEMP_FILTER_DEFINES_SVH

// property checked at every clock edge outside reset
`define ACATF_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds while reset is high
`define ACATF_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/acatf_pkg.sv */
package acatf_pkg;

   localparam int NUM_CHANNELS  = 9;
   localparam int AVERAGE_COUNT = 4;

   localparam int CHANNEL_W = 4;
   localparam int SAMPLE_W  = 12;
   localparam int MASK_W    = 9;
   localparam int TEMP_W    = 11;
   localparam int AVG_W     = 13;
   localparam int VALUE_W   = SAMPLE_W + 1;
   localparam int SUM_W     = VALUE_W + $clog2(AVERAGE_COUNT);
   localparam int CNT_W     = (AVERAGE_COUNT > 1) ? $clog2(AVERAGE_COUNT) : 1;
   localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int TEMP_CHANNEL = NUM_CHANNELS;

   localparam int FULL_SCALE  = 4096;
   localparam int TEMP_OFFSET = 838;
   localparam int TEMP_GAIN   = 621;
   localparam int TEMP_SHIFT  = 11;
   localparam int IIR_SHIFT   = 3;
   localparam int PROD_W      = 24;

   localparam logic [MASK_W-1:0] MASK_RESET = 9'd43;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register index, taken from paddr[2]
   localparam logic [0:0] CSR_INVERT_MASK = 1'b0;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [TEMP_W-1:0] peak;
   } temp_result_type;

endpackage

/* sv/adc_channel_averager_temp_filter.sv */
// an accepted req transaction passes the input register and then the result register before rsp_tvalid
// throughput: one transaction per cycle while rsp is not stalled; the per-channel accumulator
// and the temperature filter are read, updated and written back in the same cycle
// analog samples emit a result on every fourth sample of a channel, temperature on every one
// reset (synchronous, active high) clears accumulators, counts, filter, maximum and valids,
// and sets invert_mask to 43
module adc_channel_averager_temp_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [11:0] sample, [12] startup_done, [15:13] zero
   input  logic [acatf_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [3:0] channel
   input  logic [acatf_pkg::CHANNEL_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [12:0] average, [23:13] filtered_temp, [34:24] peak_temp, [39:35] zero
   output logic [acatf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [3:0] out_channel
   output logic [acatf_pkg::CHANNEL_W-1:0]       rsp_tuser,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [acatf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [acatf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [acatf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import acatf_pkg::*;

   logic [MASK_W-1:0]         mask_ff;

   logic                      in_valid_ff;
   logic [CHANNEL_W-1:0]      in_channel_ff;
   logic [SAMPLE_W-1:0]       in_sample_ff;
   logic                      in_started_ff;

   logic [SUM_W-1:0]          sum_ff   [NUM_CHANNELS];
   logic [CNT_W-1:0]          count_ff [NUM_CHANNELS];
   logic signed [TEMP_W-1:0]  temp_state_ff;
   logic signed [TEMP_W-1:0]  temp_max_ff;

   logic                      rsp_valid_ff;
   logic [CHANNEL_W-1:0]      rsp_channel_ff;
   logic [AVG_W-1:0]          rsp_average_ff;
   logic signed [TEMP_W-1:0]  rsp_filtered_ff;
   logic signed [TEMP_W-1:0]  rsp_peak_ff;

   logic                      is_analog;
   logic                      is_temp;
   logic [CH_IDX_W-1:0]       ch_idx;
   logic                      invert;
   logic [VALUE_W-1:0]        value;
   logic [SUM_W-1:0]          sum_in;
   logic [CNT_W:0]            cnt_next;
   logic [CNT_W-1:0]          count_in;
   logic                      group_done;
   logic [AVG_W-1:0]          average;
   logic                      produces;
   logic                      out_free;
   logic                      step_go;
   logic                      csr_write;
   temp_result_type           tres;

   acatf_temp_filter u_temp_filter (
      .sample     (in_sample_ff),
      .temp_state (temp_state_ff),
      .temp_max   (temp_max_ff),
      .started    (in_started_ff),
      .result     (tres)
   );

   always_comb begin
      is_analog = in_channel_ff < CHANNEL_W'(NUM_CHANNELS);
      is_temp   = in_channel_ff == CHANNEL_W'(TEMP_CHANNEL);
      ch_idx    = CH_IDX_W'(in_channel_ff);
      // channels without a mask bit are never inverted
      invert    = 1'b0;
      if (is_analog && (in_channel_ff < CHANNEL_W'(MASK_W))) begin
         invert = mask_ff[in_channel_ff];
      end
      value      = invert ? (VALUE_W'(FULL_SCALE) - {1'b0, in_sample_ff})
                          : {1'b0, in_sample_ff};
      sum_in     = sum_ff[ch_idx] + SUM_W'(value);
      cnt_next   = {1'b0, count_ff[ch_idx]} + (CNT_W+1)'(1);
      group_done = cnt_next == (CNT_W+1)'(AVERAGE_COUNT);
      count_in   = group_done ? '0 : cnt_next[CNT_W-1:0];
      average    = AVG_W'(sum_in / AVERAGE_COUNT);
      produces   = is_temp || (is_analog && group_done);
      out_free   = !rsp_valid_ff || rsp_tready;
      step_go    = in_valid_ff && (!produces || out_free);
      req_tready = !in_valid_ff || !produces || out_free;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_INVERT_MASK)) begin
         mask_ff <= csr_pwdata[MASK_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_INVERT_MASK) ? CSR_DATA_W'(mask_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_channel_ff <= req_tuser;
         in_sample_ff  <= req_tdata[SAMPLE_W-1:0];
         in_started_ff <= req_tdata[SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
         temp_state_ff <= '0;
         temp_max_ff   <= '0;
      end else if (step_go) begin
         if (is_analog) begin
            sum_ff[ch_idx]   <= group_done ? '0 : sum_in;
            count_ff[ch_idx] <= count_in;
         end
         if (is_temp) begin
            temp_state_ff <= tres.temp;
            temp_max_ff   <= tres.peak;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step_go && produces;
      end
      if (step_go && produces) begin
         rsp_channel_ff <= in_channel_ff;
         if (is_temp) begin
            rsp_average_ff  <= '0;
            rsp_filtered_ff <= tres.temp;
            rsp_peak_ff     <= tres.peak;
         end else begin
            rsp_average_ff  <= average;
            rsp_filtered_ff <= temp_state_ff;
            rsp_peak_ff     <= temp_max_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_channel_ff;
   assign rsp_tdata  = {5'b0, rsp_peak_ff, rsp_filtered_ff, rsp_average_ff};

endmodule

/* sv/acatf_temp_filter.sv */
module acatf_temp_filter (
   input  logic [acatf_pkg::SAMPLE_W-1:0]       sample,
   input  logic signed [acatf_pkg::TEMP_W-1:0]  temp_state,
   input  logic signed [acatf_pkg::TEMP_W-1:0]  temp_max,
   input  logic                                 started,
   output acatf_pkg::temp_result_type           result
);
   import acatf_pkg::*;

   logic signed [VALUE_W-1:0]  offset_s;
   logic signed [PROD_W-1:0]   product;
   logic signed [TEMP_W-1:0]   scaled;
   logic signed [TEMP_W+3:0]   acc;
   logic signed [TEMP_W-1:0]   temp_next;

   always_comb begin
      offset_s  = $signed({1'b0, sample}) - $signed(VALUE_W'(TEMP_OFFSET));
      product   = PROD_W'(offset_s) * $signed(PROD_W'(TEMP_GAIN));
      // arithmetic shifts give floor division for negative values
      scaled    = TEMP_W'(product >>> TEMP_SHIFT);
      // 7 * t as 8 * t - t
      acc       = ((TEMP_W+4)'(temp_state) <<< 3) - (TEMP_W+4)'(temp_state)
                  + (TEMP_W+4)'(scaled);
      temp_next = TEMP_W'(acc >>> IIR_SHIFT);
      result.temp = temp_next;
      result.peak = (started && (temp_next > temp_max)) ? temp_next : temp_max;
   end

endmodule

/* sv/acatf_checker.sv */
`include "adc_channel_averager_temp_filter_defines.svh"

module acatf_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [acatf_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input logic [acatf_pkg::CHANNEL_W-1:0]       req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [acatf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input logic [acatf_pkg::CHANNEL_W-1:0]       rsp_tuser,
   input logic                                  csr_psel,
   input logic                                  csr_penable,
   input logic                                  csr_pwrite,
   input logic [acatf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input logic [acatf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input logic [acatf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input logic                                  csr_pready
);
   import acatf_pkg::*;

   logic [AVG_W-1:0]      avg_field;
   logic [CHANNEL_W-1:0]  temp_ch;

   assign avg_field = rsp_tdata[AVG_W-1:0];
   assign temp_ch   = CHANNEL_W'(TEMP_CHANNEL);

   `ACATF_ASSERT_ALWAYS(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp transaction changed")

   `ACATF_ASSERT_NORST(a_reset_clears, clock, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   `ACATF_ASSERT_ALWAYS(a_channel_range, clock, reset, rsp_tvalid |-> rsp_tuser <= temp_ch, "rsp transaction for an ignored channel")

   `ACATF_ASSERT_ALWAYS(a_temp_avg_zero, clock, reset, rsp_tvalid && rsp_tuser == temp_ch |-> avg_field == '0, "temperature result with nonzero average")

   `ACATF_ASSERT_ALWAYS(a_avg_range, clock, reset, rsp_tvalid && rsp_tuser != temp_ch |-> avg_field <= AVG_W'(FULL_SCALE), "analog average above full scale")

endmodule

bind adc_channel_averager_temp_filter acatf_checker u_acatf_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import acatf_pkg::*;

   localparam int IDLE_PERCENT   = 17;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_WAIT_LIMIT = 4000;
   localparam int ITEMS_PER_SET  = 85;
   localparam int IIR_KEEP       = 7;
   localparam logic [CSR_ADDR_W-1:0] MASK_ADDR = {CSR_INVERT_MASK, 2'b00};

   typedef struct packed {
      logic [CHANNEL_W-1:0]     chan;
      logic [AVG_W-1:0]         avg;
      logic signed [TEMP_W-1:0] filt;
      logic signed [TEMP_W-1:0] peak;
   } adc_result_type;

   typedef struct {
      logic [CHANNEL_W-1:0] chan;
      logic [SAMPLE_W-1:0]  smp;
      logic                 started;
      bit                   typed;
      adc_result_type       want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [CHANNEL_W-1:0]   req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [CHANNEL_W-1:0]   rsp_tuser;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // predictor copy of the block state
   logic [SUM_W-1:0]         acc [NUM_CHANNELS];
   logic [CNT_W-1:0]         acc_count [NUM_CHANNELS];
   logic signed [TEMP_W-1:0] iir_state;
   logic signed [TEMP_W-1:0] iir_peak;
   logic [MASK_W-1:0]        mask_model;

   adc_result_type awaited_results[$];
   stim_row_type   stim_rows[$];
   adc_result_type got;
   adc_result_type want;
   int          error_count = 0;
   bit          steady = 1'b0;
   int          phase = 0;

   adc_channel_averager_temp_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic note_error(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic accumulate_or_filter(input logic [CHANNEL_W-1:0] ch,
                                       input logic [SAMPLE_W-1:0] smp,
                                       input logic started,
                                       output bit emits,
                                       output adc_result_type res);
      logic [VALUE_W-1:0] v;
      int scaled;
      int next_t;
      emits = 1'b0;
      res = '0;
      if (ch < NUM_CHANNELS) begin
         v = mask_model[ch] ? VALUE_W'(FULL_SCALE - int'(smp)) : {1'b0, smp};
         acc[ch] = acc[ch] + SUM_W'(v);
         if (acc_count[ch] == CNT_W'(AVERAGE_COUNT - 1)) begin
            emits = 1'b1;
            res.chan = ch;
            res.avg = AVG_W'(acc[ch] / AVERAGE_COUNT);
            res.filt = iir_state;
            res.peak = iir_peak;
            acc[ch] = '0;
            acc_count[ch] = '0;
         end else begin
            acc_count[ch] = acc_count[ch] + 1'b1;
         end
      end else if (ch == TEMP_CHANNEL) begin
         // arithmetic shifts of signed ints give the floor the filter needs
         scaled = ((int'(smp) - TEMP_OFFSET) * TEMP_GAIN) >>> TEMP_SHIFT;
         next_t = (int'(iir_state) * IIR_KEEP + scaled) >>> IIR_SHIFT;
         iir_state = TEMP_W'(next_t);
         if (started && iir_state > iir_peak) iir_peak = iir_state;
         emits = 1'b1;
         res.chan = ch;
         res.avg = '0;
         res.filt = iir_state;
         res.peak = iir_peak;
      end
   endtask

   // drive one conversion transaction; the expectation is queued once it is taken
   task automatic send_conversion(input logic [CHANNEL_W-1:0] ch,
                                  input logic [SAMPLE_W-1:0] smp,
                                  input logic started,
                                  input bit typed,
                                  input adc_result_type typed_want);
      int gap;
      bit taken;
      bit emits;
      adc_result_type res;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= REQ_TDATA_W'($urandom);
         req_tuser <= CHANNEL_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, started, smp};
      req_tuser <= ch;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      accumulate_or_filter(ch, smp, started, emits, res);
      if (emits) awaited_results.push_back(typed ? typed_want : res);
   endtask

   task automatic settle_block();
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [MASK_W-1:0] value);
      bit done;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MASK_ADDR;
      csr_pwdata <= {CSR_DATA_W'($urandom) >> MASK_W << MASK_W} | CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = csr_pready;
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      mask_model = value;
   endtask

   task automatic add_row(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                          input logic started, input bit typed,
                          input logic [AVG_W-1:0] avg, input logic signed [TEMP_W-1:0] filt,
                          input logic signed [TEMP_W-1:0] peak);
      stim_row_type row;
      row.chan = ch;
      row.smp = smp;
      row.started = started;
      row.typed = typed;
      row.want.chan = ch;
      row.want.avg = avg;
      row.want.filt = filt;
      row.want.peak = peak;
      stim_rows.push_back(row);
   endtask

   task automatic random_conversion();
      int r;
      logic [CHANNEL_W-1:0] ch;
      logic [SAMPLE_W-1:0] smp;
      logic started;
      r = $urandom_range(0, 99);
      if (r < 68) ch = CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
      else if (r < 90) ch = CHANNEL_W'(TEMP_CHANNEL);
      else ch = CHANNEL_W'($urandom_range(TEMP_CHANNEL + 1, 15));
      r = $urandom_range(0, 9);
      if (r == 0) smp = '0;
      else if (r == 1) smp = '1;
      else if (r < 4 && ch == TEMP_CHANNEL) smp = SAMPLE_W'($urandom_range(3000, 4095));
      else smp = SAMPLE_W'($urandom_range(0, 4095));
      // startup flag mostly low in the first set, mostly high afterwards
      if (phase == 0) started = ($urandom_range(0, 3) == 0);
      else started = ($urandom_range(0, 7) != 0);
      send_conversion(ch, smp, started, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (steady) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.chan = rsp_tuser;
         got.avg = rsp_tdata[12:0];
         got.filt = rsp_tdata[23:13];
         got.peak = rsp_tdata[34:24];
         if (awaited_results.size() == 0) begin
            note_error($sformatf("unexpected result on channel %0d", got.chan));
         end else begin
            want = awaited_results.pop_front();
            if (got.chan != want.chan)
               note_error($sformatf("out_channel %0d, want %0d", got.chan, want.chan));
            if (got.avg != want.avg)
               note_error($sformatf("ch %0d average %0d, want %0d", want.chan, got.avg,
                                    want.avg));
            if (got.filt != want.filt)
               note_error($sformatf("ch %0d filtered_temp %0d, want %0d", want.chan,
                                    got.filt, want.filt));
            if (got.peak != want.peak)
               note_error($sformatf("ch %0d peak_temp %0d, want %0d", want.chan,
                                    got.peak, want.peak));
         end
      end
   end

   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      logic [MASK_W-1:0] masks [5];
      int waited;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         acc[c] = '0;
         acc_count[c] = '0;
      end
      iir_state = '0;
      iir_peak = '0;
      mask_model = MASK_RESET;

      // reset state: temperature at offset, full-scale groups, ignored channels
      add_row(4'd9, 12'd838, 1'b1, 1'b1, 13'd0, 11'sd0, 11'sd0);
      repeat (3) add_row(4'd2, 12'd4095, 1'b0, 1'b0, '0, '0, '0);
      add_row(4'd2, 12'd4095, 1'b0, 1'b1, 13'd4095, 11'sd0, 11'sd0);
      repeat (3) add_row(4'd0, 12'd0, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd0, 12'd0, 1'b1, 1'b1, 13'd4096, 11'sd0, 11'sd0);
      add_row(4'd15, 12'd4095, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd10, 12'd0, 1'b0, 1'b0, '0, '0, '0);
      add_row(4'd9, 12'd4095, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd9, 12'd4095, 1'b0, 1'b0, '0, '0, '0);
      add_row(4'd9, 12'd0, 1'b0, 1'b0, '0, '0, '0);
      add_row(4'd9, 12'd0, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd8, 12'haaa, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd8, 12'h555, 1'b0, 1'b0, '0, '0, '0);
      add_row(4'd8, 12'd0, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd8, 12'd4095, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd3, 12'd4095, 1'b0, 1'b0, '0, '0, '0);
      add_row(4'd3, 12'd1, 1'b1, 1'b0, '0, '0, '0);
      add_row(4'd9, 12'd4095, 1'b1, 1'b0, '0, '0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send_conversion(stim_rows[i].chan, stim_rows[i].smp, stim_rows[i].started,
                         stim_rows[i].typed, stim_rows[i].want);
      req_tvalid <= 1'b0;

      masks[0] = MASK_RESET;
      masks[1] = '0;
      masks[2] = '1;
      masks[3] = MASK_W'($urandom);
      masks[4] = MASK_W'($urandom);
      for (int p = 0; p < 5; p++) begin
         // configuration only changes once the block has gone quiet
         settle_block();
         phase = p;
         steady = (p == 2);
         write_mask(masks[p]);
         for (int n = 0; n < ITEMS_PER_SET; n++) random_conversion();
         req_tvalid <= 1'b0;
      end

      waited = 0;
      while (awaited_results.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         note_error($sformatf("%0d results never arrived", awaited_results.size()));
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/acatf_pkg.sv
sv/acatf_temp_filter.sv
sv/adc_channel_averager_temp_filter.sv
sv/acatf_checker.sv
sim/tb_top.sv
